>>> sv/dcte_pkg.sv
// Shared types and constants of the detector collision time estimator.
package dcte_pkg;

	localparam int NUM_CHANNELS_DEF = 64;

	// Input and result field widths
	localparam int KIND_W    = 2;
	localparam int CHAN_W    = 6;
	localparam int CHAN_EXT_W = 8;
	localparam int RAW_W     = 16;
	localparam int CHAIN_W   = 8;
	localparam int HIT_T_W   = 33;
	localparam int EARLY_W   = 34;
	localparam int SUM_W     = 40;
	localparam int CNT_W     = 7;
	localparam int WIN_W     = 32;
	localparam int STEP_W    = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Serial divider
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 15;
	localparam int DIV_CNT_W = 6;

	typedef enum logic [KIND_W-1:0] {
		KIND_HIT    = 2'd0,
		KIND_EOE    = 2'd1,
		KIND_OFFSET = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHARGE_THR = 3'd0,
		CFG_AMP_THR    = 3'd1,
		CFG_TIME_WIN   = 3'd2,
		CFG_TDC_STEP   = 3'd3,
		CFG_DUMMY_TIME = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		RES_HIT   = 1'b0,
		RES_EVENT = 1'b1
	} res_kind_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> sv/dcte_offset_mem.sv
// Calibration offset memory with per-entry valid bits; unwritten entries read as zero.
module dcte_offset_mem import dcte_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic                    rd_en,
	input  logic [CHAN_W-1:0]       chan,
	input  logic signed [RAW_W-1:0] wr_data,
	output logic signed [RAW_W-1:0] rd_data
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic signed [RAW_W-1:0] mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] vld_q;
	logic signed [RAW_W-1:0] rd_q;
	logic [CHAN_EXT_W-1:0]   chan_ext;
	logic [IDX_W-1:0]        idx;
	logic                    in_range;

	assign chan_ext = CHAN_EXT_W'(chan);
	assign idx      = chan_ext[IDX_W-1:0];
	assign in_range = {1'b0, chan_ext} < (CHAN_EXT_W+1)'(NUM_CHANNELS);
	assign rd_data  = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en && in_range) begin
			vld_q[idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && in_range) begin
			mem[idx] <= wr_data;
		end
	end

	// Channels beyond the table and entries never written give offset zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= (in_range && vld_q[idx]) ? mem[idx] : '0;
		end
	end

endmodule

>>> sv/dcte_div.sv
// Restoring serial divider, one quotient bit per cycle.
module dcte_div import dcte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] dividend,
	input  logic [DIV_DEN_W-1:0] divisor,
	output logic [DIV_NUM_W-1:0] quotient,
	output div_stat_t            stat
);

	localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 ge;

	assign trial    = {rem_q, quo_q[DIV_NUM_W-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign diff     = trial - {1'b0, den_q};
	assign quotient = quo_q;
	assign stat     = '{busy: busy_q, done: done_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			den_q  <= divisor;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

endmodule

>>> sv/detector_collision_time_estimator.sv
// Top level: hit calibration datapath, event accumulators and end-of-event sequencer.
// Channel hit: offset read on acceptance, product in S_HIT_MUL, result loads in S_HIT_UPD.
// End of event: result loads in S_EOE_OUT, after the earliest time (rounded and shifted in
// S_EOE_MAG) and two divider passes of 40 steps each, with setup in S_EOE_MAG and S_EOE_DIV.
// Offset writes and ignored kinds give no result; input stalls outside S_IDLE and on a held result.
// Async active-low reset restores config defaults, clears event state and offset valid bits.
module detector_collision_time_estimator import dcte_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// request input
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [KIND_W-1:0]           kind,
	input  logic [CHAN_W-1:0]           channel_id,
	input  logic signed [RAW_W-1:0]     cfd_count,
	input  logic signed [RAW_W-1:0]     amplitude,
	input  logic [CHAIN_W-1:0]          chain_bits,
	input  logic                        flags_good,
	input  logic signed [RAW_W-1:0]     offset_value,
	// result output
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        result_kind,
	output logic [CHAN_W-1:0]           out_channel,
	output logic signed [HIT_T_W-1:0]   hit_time,
	output logic signed [RAW_W-1:0]     hit_charge,
	output logic [CHAIN_W-1:0]          out_chain_bits,
	output logic signed [RAW_W-1:0]     time_first,
	output logic signed [RAW_W-1:0]     time_mean,
	output logic signed [RAW_W-1:0]     time_mean_selected,
	// configuration write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HIT_MUL,
		S_HIT_UPD,
		S_EOE_MAG,
		S_EOE_DIV,
		S_EOE_WAIT,
		S_EOE_OUT
	} state_t;

	// Which event time the divider is working on
	typedef enum logic [1:0] {
		SEL_FIRST = 2'd0,
		SEL_MEAN  = 2'd1,
		SEL_TIGHT = 2'd2
	} sel_t;

	localparam logic signed [EARLY_W-1:0] EARLY_RESET = {1'b0, {(EARLY_W-1){1'b1}}};
	localparam logic [CNT_W-1:0]          COUNT_MAX   = '1;

	// Configuration registers
	logic signed [RAW_W-1:0] charge_thr_q;
	logic signed [RAW_W-1:0] amp_thr_q;
	logic [WIN_W-1:0]        time_win_q;
	logic [STEP_W-1:0]       tdc_step_q;
	logic signed [RAW_W-1:0] dummy_time_q;

	// Sequencer and item registers
	state_t                      state_q;
	sel_t                        sel_q;
	logic [CHAN_W-1:0]           chan_q;
	logic signed [RAW_W-1:0]     cfd_q;
	logic signed [RAW_W-1:0]     amp_q;
	logic [CHAIN_W-1:0]          chain_q;
	logic                        good_q;
	logic signed [HIT_T_W-1:0]   prod_q;

	// Event state
	logic signed [EARLY_W-1:0]   early_q;
	logic signed [SUM_W-1:0]     rsum_q;
	logic [CNT_W-1:0]            rcnt_q;
	logic signed [SUM_W-1:0]     tsum_q;
	logic [CNT_W-1:0]            tcnt_q;

	// End-of-event operands and results
	logic [DIV_NUM_W-1:0]        mag_q;
	logic                        neg_q;
	logic signed [RAW_W-1:0]     tf_q;
	logic signed [RAW_W-1:0]     tm_q;
	logic signed [RAW_W-1:0]     ts_q;

	// Output register
	logic                        out_valid_q;
	logic                        res_kind_q;
	logic [CHAN_W-1:0]           out_chan_q;
	logic signed [HIT_T_W-1:0]   hit_time_q;
	logic signed [RAW_W-1:0]     hit_charge_q;
	logic [CHAIN_W-1:0]          out_chain_q;
	logic signed [RAW_W-1:0]     out_tf_q;
	logic signed [RAW_W-1:0]     out_tm_q;
	logic signed [RAW_W-1:0]     out_ts_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        out_load;
	logic signed [RAW_W-1:0]     offset_rd;
	logic signed [RAW_W:0]       diff;
	logic signed [2*RAW_W+1:0]   prod_full;
	logic [HIT_T_W-1:0]          t_mag;
	logic                        hit_counts;
	logic                        in_win;
	logic                        rel_add;
	logic                        tight_add;
	logic signed [EARLY_W-1:0]   t_ext;
	logic signed [SUM_W-1:0]     sel_num;
	logic [CNT_W-1:0]            sel_cnt;
	logic [DIV_NUM_W-1:0]        sel_mag;
	logic [DIV_NUM_W-1:0]        first_quo;
	logic [DIV_NUM_W-1:0]        div_dividend;
	logic [DIV_DEN_W-1:0]        div_divisor;
	logic [DIV_NUM_W-1:0]        div_quo;
	logic                        div_start;
	div_stat_t                   div_stat;
	logic signed [RAW_W-1:0]     sat_res;

	// Round-half-away magnitude quotient to a saturated signed 16-bit time
	function automatic logic signed [RAW_W-1:0] sat_time(
		input logic [DIV_NUM_W-1:0] q,
		input logic                 neg
	);
		logic signed [RAW_W-1:0] r;
		if (!neg) begin
			r = (q > DIV_NUM_W'(32767)) ? 16'sh7FFF : q[RAW_W-1:0];
		end else begin
			r = (q > DIV_NUM_W'(32768)) ? 16'sh8000 : RAW_W'(~q[RAW_W-1:0] + 1'b1);
		end
		return r;
	endfunction

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && ((state_q == S_HIT_UPD) || (state_q == S_EOE_OUT));
	assign cfg_ready = 1'b1;

	assign out_valid          = out_valid_q;
	assign result_kind        = res_kind_q;
	assign out_channel        = out_chan_q;
	assign hit_time           = hit_time_q;
	assign hit_charge         = hit_charge_q;
	assign out_chain_bits     = out_chain_q;
	assign time_first         = out_tf_q;
	assign time_mean          = out_tm_q;
	assign time_mean_selected = out_ts_q;

	dcte_offset_mem #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_offset_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (in_acc && (kind == KIND_OFFSET)),
		.rd_en  (in_acc && (kind == KIND_HIT)),
		.chan   (channel_id),
		.wr_data(offset_value),
		.rd_data(offset_rd)
	);

	// Hit time: (cfd - offset) * tdc_step, exact in 33 bits
	assign diff      = (RAW_W+1)'(cfd_q) - (RAW_W+1)'(offset_rd);
	assign prod_full = diff * $signed({1'b0, tdc_step_q});

	// Qualification of the registered hit time
	assign t_mag      = prod_q[HIT_T_W-1] ? HIT_T_W'(-prod_q) : HIT_T_W'(prod_q);
	assign hit_counts = amp_q > charge_thr_q;
	assign in_win     = t_mag < {1'b0, time_win_q};
	assign rel_add    = hit_counts && good_q && in_win && (rcnt_q != COUNT_MAX);
	assign tight_add  = hit_counts && good_q && in_win && (amp_q > amp_thr_q)
	                    && (tcnt_q != COUNT_MAX);
	assign t_ext      = EARLY_W'(prod_q);

	// Operand selection; the earliest time bypasses the divider
	always_comb begin
		case (sel_q)
			SEL_FIRST: begin
				sel_num = SUM_W'(early_q);
				sel_cnt = '0;
			end
			SEL_MEAN: begin
				sel_num = rsum_q;
				sel_cnt = rcnt_q;
			end
			SEL_TIGHT: begin
				sel_num = tsum_q;
				sel_cnt = tcnt_q;
			end
			default: begin
				sel_num = '0;
				sel_cnt = '0;
			end
		endcase
	end

	assign sel_mag   = sel_num[SUM_W-1] ? DIV_NUM_W'(-sel_num) : DIV_NUM_W'(sel_num);
	// Earliest time in ps: add half of 256, then shift out the 1/256 fraction
	assign first_quo = (sel_mag + DIV_NUM_W'(128)) >> 8;

	// Add half the divisor for rounding away from zero
	assign div_dividend = mag_q + DIV_NUM_W'({sel_cnt, 7'b0});
	assign div_divisor  = {sel_cnt, 8'b0};
	assign div_start    = (state_q == S_EOE_DIV);
	assign sat_res      = sat_time(div_quo, neg_q);

	dcte_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			charge_thr_q <= '0;
			amp_thr_q    <= '0;
			time_win_q   <= '1;
			tdc_step_q   <= STEP_W'(3333);
			dummy_time_q <= 16'sh8000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHARGE_THR: charge_thr_q <= cfg_data[RAW_W-1:0];
				CFG_AMP_THR:    amp_thr_q    <= cfg_data[RAW_W-1:0];
				CFG_TIME_WIN:   time_win_q   <= cfg_data[WIN_W-1:0];
				CFG_TDC_STEP:   tdc_step_q   <= cfg_data[STEP_W-1:0];
				CFG_DUMMY_TIME: dummy_time_q <= cfg_data[RAW_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, event state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sel_q        <= SEL_FIRST;
			chan_q       <= '0;
			cfd_q        <= '0;
			amp_q        <= '0;
			chain_q      <= '0;
			good_q       <= 1'b0;
			prod_q       <= '0;
			early_q      <= EARLY_RESET;
			rsum_q       <= '0;
			rcnt_q       <= '0;
			tsum_q       <= '0;
			tcnt_q       <= '0;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			tf_q         <= '0;
			tm_q         <= '0;
			ts_q         <= '0;
			out_valid_q  <= 1'b0;
			res_kind_q   <= RES_HIT;
			out_chan_q   <= '0;
			hit_time_q   <= '0;
			hit_charge_q <= '0;
			out_chain_q  <= '0;
			out_tf_q     <= '0;
			out_tm_q     <= '0;
			out_ts_q     <= '0;
		end else begin
			// Load a new result when one is emitted, drop it once the sink takes it
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						chan_q  <= channel_id;
						cfd_q   <= cfd_count;
						amp_q   <= amplitude;
						chain_q <= chain_bits;
						good_q  <= flags_good;
						case (kind)
							KIND_HIT: state_q <= S_HIT_MUL;
							KIND_EOE: begin
								sel_q   <= SEL_FIRST;
								state_q <= S_EOE_MAG;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end

				S_HIT_MUL: begin
					prod_q  <= prod_full[HIT_T_W-1:0];
					state_q <= S_HIT_UPD;
				end

				// Hold until the output register is free, then update and emit together
				S_HIT_UPD: begin
					if (out_free) begin
						if (hit_counts && (t_ext < early_q)) begin
							early_q <= t_ext;
						end
						if (rel_add) begin
							rsum_q <= rsum_q + SUM_W'(prod_q);
							rcnt_q <= rcnt_q + 1'b1;
						end
						if (tight_add) begin
							tsum_q <= tsum_q + SUM_W'(prod_q);
							tcnt_q <= tcnt_q + 1'b1;
						end
						res_kind_q   <= RES_HIT;
						out_chan_q   <= chan_q;
						hit_time_q   <= prod_q;
						hit_charge_q <= amp_q;
						out_chain_q  <= chain_q;
						out_tf_q     <= '0;
						out_tm_q     <= '0;
						out_ts_q     <= '0;
						state_q      <= S_IDLE;
					end
				end

				S_EOE_MAG: begin
					neg_q <= sel_num[SUM_W-1];
					mag_q <= sel_mag;
					if (sel_q == SEL_FIRST) begin
						// Earliest time needs only a divide by 256: round and shift here
						tf_q  <= sat_time(first_quo, sel_num[SUM_W-1]);
						sel_q <= SEL_MEAN;
					end else begin
						state_q <= S_EOE_DIV;
					end
				end

				S_EOE_DIV: begin
					state_q <= S_EOE_WAIT;
				end

				S_EOE_WAIT: begin
					if (div_stat.done) begin
						case (sel_q)
							SEL_MEAN: begin
								tm_q    <= sat_res;
								sel_q   <= SEL_TIGHT;
								state_q <= S_EOE_MAG;
							end
							default: begin
								ts_q    <= sat_res;
								state_q <= S_EOE_OUT;
							end
						endcase
					end
				end

				// Emit the event times, then clear the event state
				S_EOE_OUT: begin
					if (out_free) begin
						res_kind_q   <= RES_EVENT;
						out_chan_q   <= '0;
						hit_time_q   <= '0;
						hit_charge_q <= '0;
						out_chain_q  <= '0;
						out_tf_q     <= (rcnt_q != '0) ? tf_q : dummy_time_q;
						out_tm_q     <= (rcnt_q != '0) ? tm_q : dummy_time_q;
						out_ts_q     <= (tcnt_q != '0) ? ts_q : dummy_time_q;
						early_q      <= EARLY_RESET;
						rsum_q       <= '0;
						rcnt_q       <= '0;
						tsum_q       <= '0;
						tcnt_q       <= '0;
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the detector collision time estimator.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import dcte_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 5;
	localparam int CFG_SETTLE     = 8;     // offset writes and ignored kinds retire without a result
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD      = 400;
	localparam int ITEMS_PER_PHASE = 40;
	localparam int RANDOM_PHASES  = 6;
	localparam int COUNT_LIMIT    = 127;
	localparam longint EARLIEST_IDLE = 64'sd8589934591;

	// Kind outside the enum: the block drops it without a result
	localparam logic [KIND_W-1:0]    KIND_IGNORED  = 2'd3;
	// First register index past the last defined register
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic [CHAN_W-1:0]       chan;
		logic signed [RAW_W-1:0] cfd;
		logic signed [RAW_W-1:0] amp;
		logic [CHAIN_W-1:0]      chain;
		logic                    good;
		logic signed [RAW_W-1:0] offset;
	} request_t;

	typedef struct {
		logic                      rkind;
		logic [CHAN_W-1:0]         chan;
		logic signed [HIT_T_W-1:0] htime;
		logic signed [RAW_W-1:0]   charge;
		logic [CHAIN_W-1:0]        chain;
		logic signed [RAW_W-1:0]   first;
		logic signed [RAW_W-1:0]   mean;
		logic signed [RAW_W-1:0]   mean_sel;
	} record_t;

	// Tracks offsets, settings and event sums; predicts and checks every record.
	class collision_time_board;
		logic signed [RAW_W-1:0] chan_offset [NUM_CHANNELS_DEF];
		logic signed [RAW_W-1:0] charge_thr;
		logic signed [RAW_W-1:0] amp_thr;
		logic signed [RAW_W-1:0] dummy_ps;
		logic [WIN_W-1:0]        window;
		logic [STEP_W-1:0]       step;
		longint                  earliest;
		longint                  relaxed_sum;
		longint                  tight_sum;
		int                      relaxed_n;
		int                      tight_n;
		record_t                 pending_records[$];
		int unsigned             mismatches;

		function new();
			foreach (chan_offset[i])
				chan_offset[i] = '0;
			charge_thr = '0;
			amp_thr    = '0;
			window     = '1;
			step       = 16'd3333;
			dummy_ps   = 16'sh8000;
			mismatches = 0;
			clear_event();
		endfunction

		function void clear_event();
			earliest    = EARLIEST_IDLE;
			relaxed_sum = 0;
			tight_sum   = 0;
			relaxed_n   = 0;
			tight_n     = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_CHARGE_THR: charge_thr = data[RAW_W-1:0];
				CFG_AMP_THR:    amp_thr    = data[RAW_W-1:0];
				CFG_TIME_WIN:   window     = data[WIN_W-1:0];
				CFG_TDC_STEP:   step       = data[STEP_W-1:0];
				CFG_DUMMY_TIME: dummy_ps   = data[RAW_W-1:0];
				default: ;
			endcase
		endfunction

		// Divide by 256 ps units times the count, round half away from zero, saturate.
		function logic signed [RAW_W-1:0] to_ps(longint total, int n);
			longint unsigned den;
			longint unsigned mag;
			longint unsigned q;
			longint          r;
			den = 256 * n;
			mag = (total < 0) ? -total : total;
			q   = (mag + den / 2) / den;
			r   = (total < 0) ? -longint'(q) : longint'(q);
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			return r[RAW_W-1:0];
		endfunction

		function void take_request(request_t r);
			longint  t;
			longint  mag;
			record_t want;
			want = '{default: '0};
			case (r.kind)
				KIND_HIT: begin
					t = (longint'(r.cfd) - longint'(chan_offset[r.chan])) * longint'(step);
					if (r.amp > charge_thr) begin
						mag = (t < 0) ? -t : t;
						if (t < earliest)
							earliest = t;
						if (r.good && mag < longint'(window)) begin
							if (relaxed_n < COUNT_LIMIT) begin
								relaxed_sum += t;
								relaxed_n++;
							end
							if (r.amp > amp_thr && tight_n < COUNT_LIMIT) begin
								tight_sum += t;
								tight_n++;
							end
						end
					end
					want.rkind  = RES_HIT;
					want.chan   = r.chan;
					want.htime  = t[HIT_T_W-1:0];
					want.charge = r.amp;
					want.chain  = r.chain;
					pending_records.push_back(want);
				end
				KIND_EOE: begin
					want.rkind    = RES_EVENT;
					want.first    = dummy_ps;
					want.mean     = dummy_ps;
					want.mean_sel = dummy_ps;
					// earliest time only reported when the relaxed average has entries
					if (relaxed_n > 0) begin
						want.first = to_ps(earliest, 1);
						want.mean  = to_ps(relaxed_sum, relaxed_n);
					end
					if (tight_n > 0)
						want.mean_sel = to_ps(tight_sum, tight_n);
					pending_records.push_back(want);
					clear_event();
				end
				KIND_OFFSET: chan_offset[r.chan] = r.offset;
				default: ;
			endcase
		endfunction

		function void compare_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				mismatches++;
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		function void check_record(record_t got);
			record_t want;
			if (pending_records.size() == 0) begin
				mismatches++;
				$error("result with no request pending (result_kind %0d)", got.rkind);
				return;
			end
			want = pending_records.pop_front();
			compare_field("result_kind", want.rkind, got.rkind);
			compare_field("out_channel", want.chan, got.chan);
			compare_field("hit_time", want.htime, got.htime);
			compare_field("hit_charge", want.charge, got.charge);
			compare_field("out_chain_bits", want.chain, got.chain);
			compare_field("time_first", want.first, got.first);
			compare_field("time_mean", want.mean, got.mean);
			compare_field("time_mean_selected", want.mean_sel, got.mean_sel);
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic [KIND_W-1:0]           kind;
	logic [CHAN_W-1:0]           channel_id;
	logic signed [RAW_W-1:0]     cfd_count;
	logic signed [RAW_W-1:0]     amplitude;
	logic [CHAIN_W-1:0]          chain_bits;
	logic                        flags_good;
	logic signed [RAW_W-1:0]     offset_value;
	logic                        out_valid;
	logic                        out_stall;
	logic                        result_kind;
	logic [CHAN_W-1:0]           out_channel;
	logic signed [HIT_T_W-1:0]   hit_time;
	logic signed [RAW_W-1:0]     hit_charge;
	logic [CHAIN_W-1:0]          out_chain_bits;
	logic signed [RAW_W-1:0]     time_first;
	logic signed [RAW_W-1:0]     time_mean;
	logic signed [RAW_W-1:0]     time_mean_selected;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;

	// Shared between the request driver and the result-side stall process
	bit idle_enabled      = 1'b1;
	bit long_hold_pending = 1'b0;

	collision_time_board board = new();

	detector_collision_time_estimator DUT (.*);

	always begin
		#(CLK_HALF) clk = 1'b1;
		#(CLK_HALF) clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// Random field helpers
	// ---------------------------------------------------------------------------------
	function automatic logic [15:0] any16();
		return 16'($urandom);
	endfunction

	// Mostly small values so that windows, means and rounding stay interesting
	function automatic logic signed [15:0] spread16();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50)
			return 16'($urandom_range(0, 100) - 50);
		if (p < 80)
			return 16'($urandom_range(0, 4000) - 2000);
		return any16();
	endfunction

	function automatic logic signed [15:0] random_threshold();
		if ($urandom_range(0, 1) == 1)
			return 16'($urandom_range(0, 2500) - 2000);
		return any16();
	endfunction

	function automatic logic [31:0] random_window();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(1, 1 << 26);
	endfunction

	function automatic logic [15:0] random_step();
		if ($urandom_range(0, 1) == 1)
			return 16'($urandom_range(1, 5000));
		return 16'($urandom_range(1, 65535));
	endfunction

	function automatic request_t build_request(logic [KIND_W-1:0] k, logic [CHAN_W-1:0] ch,
			logic signed [15:0] cfd, logic signed [15:0] amp, logic [7:0] chain,
			logic good, logic signed [15:0] off);
		request_t r;
		r.kind   = k;
		r.chan   = ch;
		r.cfd    = cfd;
		r.amp    = amp;
		r.chain  = chain;
		r.good   = good;
		r.offset = off;
		return r;
	endfunction

	// Fill the fields a kind does not use with noise too
	function automatic request_t random_request(logic [KIND_W-1:0] k);
		request_t r;
		r = build_request(k, 6'($urandom), spread16(), any16(), 8'($urandom),
			1'($urandom), any16());
		if (k == KIND_HIT) begin
			if ($urandom_range(0, 1) == 1)
				r.amp = 16'($urandom_range(0, 2200) - 200);
			r.good = ($urandom_range(0, 99) < 85);
		end
		if (k == KIND_OFFSET && $urandom_range(0, 9) < 7)
			r.offset = 16'($urandom_range(0, 60) - 30);
		return r;
	endfunction

	// Sender gap: mostly back to back, some short pauses, a few long ones
	function automatic int sender_gap();
		int p;
		if (!idle_enabled)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// ---------------------------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------------------------
	// Present one request, hold it until accepted, then note it for prediction.
	// Valid stays high into the next request when there is no gap.
	task automatic send_request(input request_t r);
		int gap;
		in_valid     <= 1'b1;
		kind         <= r.kind;
		channel_id   <= r.chan;
		cfd_count    <= r.cfd;
		amplitude    <= r.amp;
		chain_bits   <= r.chain;
		flags_good   <= r.good;
		offset_value <= r.offset;
		do
			@(posedge clk);
		while (in_stall);
		board.take_request(r);
		gap = sender_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every predicted record; the check follows each clock edge
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending_records.size() != 0);
	endtask

	// Leave cfg_valid high; the caller lowers it after the last write of a batch
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.write_register(idx, data);
	endtask

	// Reprogram all registers on an idle block. 16-bit registers get junk upper bits,
	// and an undefined index is written first to show it is ignored.
	task automatic apply_setting(input logic signed [15:0] chg, input logic signed [15:0] amp,
			input logic [31:0] win, input logic [15:0] step, input logic signed [15:0] dummy);
		wait_results_drained();
		repeat (CFG_SETTLE) @(posedge clk);
		write_reg(CFG_IDX_SPARE + 3'($urandom_range(0, 2)), $urandom);
		write_reg(CFG_CHARGE_THR, {any16(), chg});
		write_reg(CFG_AMP_THR, {any16(), amp});
		write_reg(CFG_TIME_WIN, win);
		write_reg(CFG_TDC_STEP, {any16(), step});
		write_reg(CFG_DUMMY_TIME, {any16(), dummy});
		cfg_valid <= 1'b0;
	endtask

	task automatic random_setting();
		apply_setting(random_threshold(), random_threshold(), random_window(), random_step(),
			any16());
	endtask

	// Mostly well-formed events with random content; some stray end-of-event items,
	// unterminated events, offset updates and ignored kinds mixed in
	task automatic run_events(input int n);
		int sent;
		int hits;
		int sel;
		sent = 0;
		while (sent < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				send_request(random_request(KIND_IGNORED));
			end else if (sel < 8) begin
				send_request(random_request(KIND_EOE));
				sent++;
			end else if (sel < 20) begin
				send_request(random_request(KIND_OFFSET));
				sent++;
			end else begin
				hits = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
				for (int i = 0; i < hits; i++)
					send_request(random_request(KIND_HIT));
				sent += hits;
				if ($urandom_range(0, 9) != 0) begin
					send_request(random_request(KIND_EOE));
					sent++;
				end
			end
		end
	endtask

	// One event of good, strong hits, closed by an end of event
	task automatic run_strong_event(input int hits);
		request_t r;
		for (int i = 0; i < hits; i++) begin
			r      = random_request(KIND_HIT);
			r.good = 1'b1;
			r.amp  = 16'($urandom_range(60, 32767));
			send_request(r);
		end
		send_request(random_request(KIND_EOE));
	endtask

	// ---------------------------------------------------------------------------------
	// Result side: random stall, plus one long hold-off on request
	// ---------------------------------------------------------------------------------
	initial begin : result_stall
		int left;
		int p;
		bit level;
		left  = 0;
		level = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (left > 0) begin
				left--;
			end else if (long_hold_pending) begin
				// hold off long enough for the block to back up into its input
				long_hold_pending = 1'b0;
				level = 1'b1;
				left  = LONG_HOLD;
			end else if (!idle_enabled) begin
				level = 1'b0;
			end else begin
				p = $urandom_range(0, 99);
				if (p < 60) begin
					level = 1'b0;
					left  = $urandom_range(0, 8);
				end else if (p < 92) begin
					level = 1'b1;
					left  = $urandom_range(0, 2);
				end else begin
					level = 1'b1;
					left  = $urandom_range(3, 39);
				end
			end
			out_stall <= level;
		end
	end

	// Sample outputs with pre-edge values; check every accepted record in order
	always @(posedge clk) begin : result_monitor
		record_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.rkind    = result_kind;
			got.chan     = out_channel;
			got.htime    = hit_time;
			got.charge   = hit_charge;
			got.chain    = out_chain_bits;
			got.first    = time_first;
			got.mean     = time_mean;
			got.mean_sel = time_mean_selected;
			board.check_record(got);
		end
	end

	// Watchdog: count edges with no handshake on any channel
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------------------
	initial begin : stimulus
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		kind         <= KIND_HIT;
		channel_id   <= '0;
		cfd_count    <= '0;
		amplitude    <= '0;
		chain_bits   <= '0;
		flags_good   <= 1'b0;
		offset_value <= '0;
		cfg_valid    <= 1'b0;
		cfg_index    <= CFG_CHARGE_THR;
		cfg_data     <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: load extreme offsets, then hit against them
		send_request(build_request(KIND_OFFSET, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sh7FFF));
		send_request(build_request(KIND_OFFSET, 6'd63, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sh8000));
		send_request(build_request(KIND_OFFSET, 6'd1, 16'sd0, 16'sd0, 8'h00, 1'b0, -16'sd5));
		send_request(build_request(KIND_HIT, 6'd0, 16'sh8000, 16'sh7FFF, 8'hFF, 1'b1, 16'sd0));
		send_request(build_request(KIND_HIT, 6'd63, 16'sh7FFF, 16'sd1, 8'hA5, 1'b1, 16'sd0));
		// charge equal to the threshold does not count
		send_request(build_request(KIND_HIT, 6'd1, 16'sd0, 16'sd0, 8'h5A, 1'b1, 16'sd0));
		send_request(build_request(KIND_HIT, 6'd2, 16'sd7, 16'sh8000, 8'h00, 1'b0, 16'sd0));
		send_request(build_request(KIND_IGNORED, 6'd3, 16'sd1, 16'sd1, 8'h11, 1'b1, 16'sd9));
		send_request(build_request(KIND_EOE, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sd0));
		// empty event reports the dummy time everywhere
		send_request(build_request(KIND_EOE, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sd0));
		// bad flags: earliest moves but nothing averaged, so the earliest time is gated
		send_request(build_request(KIND_HIT, 6'd2, 16'sd100, 16'sd5, 8'h3C, 1'b0, 16'sd0));
		send_request(build_request(KIND_EOE, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sd0));

		// Widest hit times: both saturation directions, tight average never fed
		apply_setting(16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF, 16'hFFFF, 16'sh7FFF);
		send_request(build_request(KIND_HIT, 6'd0, 16'sh8000, 16'sh7FFF, 8'h81, 1'b1, 16'sd0));
		send_request(build_request(KIND_HIT, 6'd63, 16'sh7FFF, -16'sd32767, 8'h7E, 1'b1, 16'sd0));
		send_request(build_request(KIND_HIT, 6'd5, 16'sd3, 16'sh8000, 8'h00, 1'b1, 16'sd0));
		send_request(build_request(KIND_EOE, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sd0));

		// Zero window: no hit can join an average
		apply_setting(16'sh8000, 16'sd0, 32'd0, 16'd1, 16'sd1234);
		send_request(build_request(KIND_HIT, 6'd3, 16'sd0, 16'sd10, 8'h01, 1'b1, 16'sd0));
		send_request(build_request(KIND_EOE, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sd0));

		// Unit step: exact half picoseconds round away from zero; window edge excluded
		apply_setting(16'sd0, 16'sd0, 32'd200, 16'd1, 16'sh8000);
		send_request(build_request(KIND_HIT, 6'd10, 16'sd128, 16'sd1, 8'h02, 1'b1, 16'sd0));
		send_request(build_request(KIND_EOE, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sd0));
		send_request(build_request(KIND_HIT, 6'd10, -16'sd128, 16'sd1, 8'h04, 1'b1, 16'sd0));
		send_request(build_request(KIND_HIT, 6'd11, 16'sd200, 16'sd1, 8'h08, 1'b1, 16'sd0));
		send_request(build_request(KIND_EOE, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sd0));

		// Zero step: every hit time is zero; relaxed average only
		apply_setting(-16'sd1, 16'sd100, 32'd1, 16'd0, any16());
		send_request(build_request(KIND_HIT, 6'd0, 16'sd5, 16'sd50, 8'h10, 1'b1, 16'sd0));
		send_request(build_request(KIND_EOE, 6'd0, 16'sd0, 16'sd0, 8'h00, 1'b0, 16'sd0));

		// Random phases, each under a new setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			// one phase runs with no idling on either side
			idle_enabled = (phase != 2);
			if (phase == 1) begin
				// permissive setting and an event long enough to saturate both counts
				apply_setting(-16'sd100, 16'sd50, 32'hFFFF_FFFF, random_step(), any16());
				run_strong_event(140);
			end else begin
				random_setting();
			end
			if (phase == 3) begin
				// stall the results for a long stretch while requests keep coming
				long_hold_pending = 1'b1;
				idle_enabled      = 1'b0;
				run_strong_event(40);
				idle_enabled      = 1'b1;
			end
			run_events(ITEMS_PER_PHASE / 2);
			// pause the sender until every record is back
			wait_results_drained();
			run_events(ITEMS_PER_PHASE / 2);
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
